/* rtl/yrt_pkg.sv */
// Shared types and constants for the packed-table YUV to RGB888 converter.
// No dependencies; imported by yrt_front, yrt_back and the top level.
package yrt_pkg;

  // Input stream field widths and tdata layout (lowest bit first).
  localparam int unsigned IndexW   = 10;
  localparam int unsigned WordW    = 32;
  localparam int unsigned SampleW  = 8;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned InDataW  = 80;   // 74 payload bits, padded to 10 bytes
  localparam int unsigned OutDataW = 48;   // six color bytes

  localparam int unsigned IdxLsb   = 0;
  localparam int unsigned WordLsb  = IdxLsb + IndexW;
  localparam int unsigned ULsb     = WordLsb + WordW;
  localparam int unsigned VLsb     = ULsb + SampleW;
  localparam int unsigned YTopLsb  = VLsb + SampleW;
  localparam int unsigned YBotLsb  = YTopLsb + SampleW;

  // Operation selector carried in tuser.
  typedef enum logic {
    InOpLoad    = 1'b0,
    InOpConvert = 1'b1
  } yrt_in_op_e;

  // Table bank from the upper two bits of the load index.
  typedef enum logic [1:0] {
    BankLuma = 2'd0,
    BankU    = 2'd1,
    BankV    = 2'd2,
    BankNone = 2'd3
  } yrt_bank_e;

  // Classified command passed from front to back.
  typedef enum logic [1:0] {
    CmdWrLuma  = 2'd0,
    CmdWrU     = 2'd1,
    CmdWrV     = 2'd2,
    CmdConvert = 2'd3
  } yrt_cmd_e;

  // For writes: addr = slot within the bank, data = table word.
  // For converts: data = {luma_bottom, luma_top, chroma_v, chroma_u}.
  typedef struct packed {
    yrt_cmd_e            kind;
    logic [SampleW-1:0]  addr;
    logic [WordW-1:0]    data;
  } yrt_cmd_t;

  // Overflow fixup and channel positions in the packed word.
  localparam logic [WordW-1:0] FixMask    = 32'h4008_0100;
  localparam int unsigned      RedShift   = 0;
  localparam int unsigned      GreenShift = 22;
  localparam int unsigned      BlueShift  = 11;

endpackage

/* rtl/yrt_front.sv */
// Front end: accepts stream requests, classifies them into table writes or
// converts, drops out-of-range loads, and queues commands. Uses yrt_pkg.
module yrt_front import yrt_pkg::*; #(
  parameter int unsigned QueueDepth = 4   // 2 or more
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_op_i,
  input  logic [InDataW-1:0] in_data_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output yrt_cmd_t           cmd_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  yrt_cmd_t            queue_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  yrt_cmd_t  cmd_new;
  logic      keep;
  logic      push;
  logic      pop;
  yrt_bank_e bank;

  assign in_ready_o = (count_q != CntW'(QueueDepth));
  assign bank       = yrt_bank_e'(in_data_i[IdxLsb+IndexW-1 -: 2]);

  // Classify the request.
  always_comb begin
    cmd_new.addr = in_data_i[IdxLsb +: SampleW];
    cmd_new.data = in_data_i[WordLsb +: WordW];
    cmd_new.kind = CmdConvert;
    keep         = 1'b1;
    if (yrt_in_op_e'(in_op_i) == InOpConvert) begin
      cmd_new.data = {in_data_i[YBotLsb +: SampleW], in_data_i[YTopLsb +: SampleW],
                      in_data_i[VLsb +: SampleW],    in_data_i[ULsb +: SampleW]};
    end else begin
      unique case (bank)
        BankLuma: cmd_new.kind = CmdWrLuma;
        BankU:    cmd_new.kind = CmdWrU;
        BankV:    cmd_new.kind = CmdWrV;
        default:  keep = 1'b0;   // slot beyond the store: ignored
      endcase
    end
  end

  assign push        = in_valid_i && in_ready_o && keep;
  assign cmd_valid_o = (count_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

/* rtl/yrt_back.sv */
// Back end: three table banks (luma, U, V), summing and overflow fixup
// pipeline, and the result register. Uses yrt_pkg.
module yrt_back import yrt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  yrt_cmd_t            cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o
);

  localparam int unsigned Entries = 1 << SampleW;

  logic [WordW-1:0] luma_mem [Entries];
  logic [WordW-1:0] u_mem    [Entries];
  logic [WordW-1:0] v_mem    [Entries];

  logic adv;
  logic pop;
  logic is_conv;

  logic             a_valid_q, b_valid_q, c_valid_q, d_valid_q, out_valid_q;
  logic [WordW-1:0] u_rd_q, v_rd_q, yt_rd_q, yb_rd_q;
  logic [WordW-1:0] uv_q, yt_b_q, yb_b_q;
  logic [WordW-1:0] top_c_q, bot_c_q;
  logic [WordW-1:0] top_d_q, bot_d_q;
  logic             top_nz_q, bot_nz_q;
  logic [OutDataW-1:0] out_data_q;

  logic [WordW-1:0] top_pre, bot_pre;
  logic             top_nz, bot_nz;
  logic [WordW-1:0] top_fix, bot_fix;

  // First half of the fixup: OR in the spread flag bits.
  function automatic logic [WordW:0] fix_pre(input logic [WordW-1:0] w);
    logic [WordW-1:0] f;
    logic [WordW-1:0] fs;
    f  = w & FixMask;
    fs = f - (f >> 8);
    return {(f != '0), (f != '0) ? (w | fs) : w};
  endfunction

  // Second half: clamp correction add.
  function automatic logic [WordW-1:0] fix_post(input logic [WordW-1:0] w,
                                                input logic nz);
    return nz ? w + ((FixMask & ~(w >> 1)) >> 8) : w;
  endfunction

  function automatic logic [3*ByteW-1:0] rgb(input logic [WordW-1:0] w);
    return {w[BlueShift +: ByteW], w[GreenShift +: ByteW], w[RedShift +: ByteW]};
  endfunction

  // Whole pipeline moves together; it holds while the result waits.
  assign adv         = !out_valid_q || out_ready_i;
  assign cmd_ready_o = adv;
  assign pop         = cmd_valid_i && adv;
  assign is_conv     = (cmd_i.kind == CmdConvert);

  // Table writes.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      case (cmd_i.kind)
        CmdWrLuma: luma_mem[cmd_i.addr] <= cmd_i.data;
        CmdWrU:    u_mem[cmd_i.addr]    <= cmd_i.data;
        CmdWrV:    v_mem[cmd_i.addr]    <= cmd_i.data;
        default:   ;
      endcase
    end
  end

  // Registered table reads: one port on U and V, two on luma.
  always_ff @(posedge clk_i) begin
    if (pop && is_conv) begin
      u_rd_q  <= u_mem[cmd_i.data[0 +: SampleW]];
      v_rd_q  <= v_mem[cmd_i.data[SampleW +: SampleW]];
      yt_rd_q <= luma_mem[cmd_i.data[2*SampleW +: SampleW]];
      yb_rd_q <= luma_mem[cmd_i.data[3*SampleW +: SampleW]];
    end
  end

  always_comb begin
    {top_nz, top_pre} = fix_pre(top_c_q);
    {bot_nz, bot_pre} = fix_pre(bot_c_q);
    top_fix = fix_post(top_d_q, top_nz_q);
    bot_fix = fix_post(bot_d_q, bot_nz_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      uv_q       <= u_rd_q + v_rd_q;
      yt_b_q     <= yt_rd_q;
      yb_b_q     <= yb_rd_q;
      top_c_q    <= uv_q + yt_b_q;
      bot_c_q    <= uv_q + yb_b_q;
      top_d_q    <= top_pre;
      bot_d_q    <= bot_pre;
      top_nz_q   <= top_nz;
      bot_nz_q   <= bot_nz;
      out_data_q <= {rgb(bot_fix), rgb(top_fix)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      d_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q   <= cmd_valid_i && is_conv;
      b_valid_q   <= a_valid_q;
      c_valid_q   <= b_valid_q;
      d_valid_q   <= c_valid_q;
      out_valid_q <= d_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* rtl/yuv420_to_rgb888_table_convert.sv */
// Top level of the packed-table YUV to RGB888 converter.
// Depends on yrt_pkg, yrt_front and yrt_back.
//
// Usage:
//   Slave stream carries requests. tuser selects the operation: a load writes
//   one 32-bit word into the 768-slot table store (slots 0-255 luma, 256-511
//   U, 512-767 V; slots 768-1023 are dropped), a convert turns one U/V pair
//   plus the two luma samples of a column into two RGB888 pixels.
//   Load the whole store before converting; an unwritten slot reads garbage.
//   Master stream carries one result per convert; loads produce none.
// Path: a convert passes the queue, table read, U+V sum, luma add, fixup flags
//   and fixup add registers, in that order.
// Throughput: one request per cycle unless the output stalls. The table
//   store is split into three banks so the four reads of a convert (U, V and
//   two luma via the dual read port of the luma bank) issue in a single cycle.
// Stalls: the back pipeline keeps moving while its output register is empty
//   and holds once a result waits there with m_axis_tready low; the command
//   queue (QueueDepth entries) keeps taking requests until it fills, then
//   s_axis_tready drops.
// Reset: clears the queue and all pipeline valid flags; table contents are
//   not cleared.
module yuv420_to_rgb888_table_convert import yrt_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [9:0] table_index, [41:10] table_word, [49:42] chroma_u, [57:50] chroma_v,
  // [65:58] luma_top, [73:66] luma_bottom, [79:74] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [0] operation
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] red_top, [15:8] green_top, [23:16] blue_top,
  // [31:24] red_bottom, [39:32] green_bottom, [47:40] blue_bottom
  output logic [OutDataW-1:0] m_axis_tdata
);

  logic     cmd_valid;
  logic     cmd_ready;
  yrt_cmd_t cmd;

  yrt_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  yrt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
